// ===== rtl/core/sii_pkg.sv =====
// ----------------------------------------------------------------------------
// sii_pkg: shared types and constants of the safety input interlock
// Pin count, action and mode codes, register indexes and the structs that
// pass between the pin lanes, the merge sequencer and the top level.
// ----------------------------------------------------------------------------
package sii_pkg;

  // Number of physical pins handled by the interlock (1 to 32).
  localparam int PIN_COUNT = 32;
  localparam int IDX_W     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  // Field widths fixed by the interface.
  localparam int LEVEL_W   = 32;
  localparam int MASK_W    = 32;
  localparam int ACTION_W  = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIN_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_ACTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_INVERT  = 2'd2;

  // Safety action of one pin.
  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_ESTOP        = 2'd1,
    ACT_PAUSE_TOGGLE = 2'd2,
    ACT_HOME_ALL     = 2'd3
  } act_t;

  // Item mode.
  typedef enum logic [1:0] {
    MODE_TICK        = 2'd0,
    MODE_SET_PAUSE   = 2'd1,
    MODE_CLEAR       = 2'd2,
    MODE_RESET_ESTOP = 2'd3
  } mode_t;

  // Per-pin mapping as seen by a lane.
  typedef struct packed {
    logic en;
    logic invert;
    act_t act;
  } pin_cfg_t;

  // Per-pin result captured by a lane at the start of a tick.
  typedef struct packed {
    logic en;
    logic active;
    logic rising;
    act_t act;
  } pin_t;

  // Input transfer as seen by the merge sequencer.
  typedef struct packed {
    logic  xfer;
    mode_t mode;
    logic  pause_value;
  } start_t;

  // One result item.
  typedef struct packed {
    logic paused_flag;
    logic estop_flag;
    logic home_request;
    logic hardware_advance;
  } result_t;

endpackage

// ===== rtl/core/sii_if.sv =====
// ----------------------------------------------------------------------------
// sii_if: handshake channels of the safety input interlock
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Input item channel.
interface sii_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [sii_pkg::LEVEL_W-1:0] input_levels;
  logic                        pause_value;

  modport source (output valid, output mode, output input_levels,
                  output pause_value, input ready);
  modport sink   (input valid, input mode, input input_levels,
                  input pause_value, output ready);
endinterface

// Result channel.
interface sii_out_if;
  logic valid;
  logic ready;
  logic paused_flag;
  logic estop_flag;
  logic home_request;
  logic hardware_advance;

  modport source (output valid, output paused_flag, output estop_flag,
                  output home_request, output hardware_advance, input ready);
  modport sink   (input valid, input paused_flag, input estop_flag,
                  input home_request, input hardware_advance, output ready);
endinterface

// Configuration write channel.
interface sii_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sii_pkg::CFG_IDX_W-1:0] index;
  logic [sii_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sii_pin_lane.sv =====
// ----------------------------------------------------------------------------
// sii_pin_lane: evaluation of one input pin
// Applies the pin's inversion, detects a rising edge against the stored
// last active level and captures the pin's result for the merge walk.
// ----------------------------------------------------------------------------
module sii_pin_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              capture,
  input  logic              level,
  input  sii_pkg::pin_cfg_t pin_cfg,
  output sii_pkg::pin_t     pin
);

  logic          last_r;
  logic          last_nxt;
  logic          active;
  sii_pkg::pin_t pin_r;
  sii_pkg::pin_t pin_nxt;

  // Active level and edge against the previous tick.
  always_comb begin
    active   = level ^ pin_cfg.invert;
    last_nxt = last_r;
    pin_nxt  = pin_r;
    if (capture) begin
      pin_nxt.en     = pin_cfg.en;
      pin_nxt.active = active;
      pin_nxt.rising = active & ~last_r;
      pin_nxt.act    = pin_cfg.act;
      // A disabled pin keeps its last level.
      if (pin_cfg.en) begin
        last_nxt = active;
      end
    end
  end

  // Last level is state; the captured result is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pin_r <= pin_nxt;
  end

  assign pin = pin_r;

endmodule

// ===== rtl/core/sii_merge.sv =====
// ----------------------------------------------------------------------------
// sii_merge: flag sequencer of the safety input interlock
// Walks the lane results one pin per cycle in ascending order, updating the
// latched e-stop and pause flags, applies mode items and holds the result.
// ----------------------------------------------------------------------------
module sii_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sii_pkg::start_t      start,
  input  sii_pkg::pin_t        pins [sii_pkg::PIN_COUNT],
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output sii_pkg::result_t     result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                    state_r,     state_nxt;
  logic [sii_pkg::IDX_W-1:0] idx_r,       idx_nxt;
  logic                      estop_r,     estop_nxt;
  logic                      pause_r,     pause_nxt;
  logic                      home_r,      home_nxt;
  logic                      adv_r,       adv_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sii_pkg::result_t          result_r,    result_nxt;
  sii_pkg::pin_t             cur;

  assign cur = pins[idx_r];

  // Sequencer and flag updates.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    estop_nxt     = estop_r;
    pause_nxt     = pause_r;
    home_nxt      = home_r;
    adv_nxt       = adv_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (start.xfer) begin
          home_nxt  = 1'b0;
          adv_nxt   = 1'b0;
          state_nxt = S_FIN;
          case (start.mode)
            sii_pkg::MODE_TICK: begin
              adv_nxt   = ~pause_r;
              idx_nxt   = '0;
              state_nxt = S_WALK;
            end
            sii_pkg::MODE_SET_PAUSE: begin
              pause_nxt = start.pause_value;
            end
            sii_pkg::MODE_CLEAR: begin
              estop_nxt = 1'b0;
              pause_nxt = 1'b0;
            end
            default: begin
              estop_nxt = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        // One pin per cycle; later pins see the flags left by earlier ones.
        if (cur.en) begin
          case (cur.act)
            sii_pkg::ACT_ESTOP: begin
              if (cur.active) begin
                estop_nxt = 1'b1;
                pause_nxt = 1'b1;
              end else begin
                estop_nxt = 1'b0;
              end
            end
            sii_pkg::ACT_PAUSE_TOGGLE: begin
              if (cur.rising && !estop_r) begin
                pause_nxt = ~pause_r;
              end
            end
            sii_pkg::ACT_HOME_ALL: begin
              if (cur.rising && !pause_r && !estop_r) begin
                home_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if (idx_r == sii_pkg::IDX_W'(sii_pkg::PIN_COUNT - 1)) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FIN: begin
        // Load the output register as soon as it is free.
        if (!out_valid_r || out_ready) begin
          result_nxt.paused_flag      = pause_r;
          result_nxt.estop_flag       = estop_r;
          result_nxt.home_request     = home_r;
          result_nxt.hardware_advance = adv_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      estop_r     <= 1'b0;
      pause_r     <= 1'b0;
      home_r      <= 1'b0;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      estop_r     <= estop_nxt;
      pause_r     <= pause_nxt;
      home_r      <= home_nxt;
      adv_r       <= adv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign result    = result_r;

  // A tick transfer starts the walk at pin zero.
  a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (start.xfer && start.mode == sii_pkg::MODE_TICK)
      |=> (state_r == S_WALK && idx_r == '0))
    else $error("tick transfer did not start the pin walk at pin zero");

  // A mode item goes straight to the result stage.
  a_mode_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (start.xfer && start.mode != sii_pkg::MODE_TICK)
      |=> (state_r == S_FIN && !home_r && !adv_r))
    else $error("mode item did not go to the result stage cleanly");

  // The result stage fills a free output register and goes back to idle.
  a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result stage did not load a free output register");

  // While walking, the walk index steps by one on every pin but the last.
  a_idx_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && idx_r != sii_pkg::IDX_W'(sii_pkg::PIN_COUNT - 1))
      |=> (state_r == S_WALK && idx_r == $past(idx_r) + 1'b1))
    else $error("pin walk skipped or stalled");

endmodule

// ===== rtl/core/safety_input_interlock.sv =====
// ----------------------------------------------------------------------------
// safety_input_interlock: latched e-stop, pause and homing from input pins
// A tick transfer is captured into the pin lanes, then the merge walk steps
//   over the 32 pins, one pin per cycle; a mode item's result needs no walk.
// A new item is accepted only while the sequencer is idle, i.e. once the last
//   result has been loaded into the output register.
// Reset (synchronous, active low) clears the flags, the last pin levels and
//   all configuration registers.
// ----------------------------------------------------------------------------
module safety_input_interlock (
  input  logic      clk,
  input  logic      rst_n,
  sii_in_if.sink    in_ch,
  sii_out_if.source out_ch,
  sii_cfg_if.sink   cfg_ch
);

  logic [sii_pkg::MASK_W-1:0]   enable_r,  enable_nxt;
  logic [sii_pkg::ACTION_W-1:0] action_r,  action_nxt;
  logic [sii_pkg::MASK_W-1:0]   invert_r,  invert_nxt;
  logic                         in_ready;
  logic                         in_xfer;
  logic                         capture;
  sii_pkg::start_t              start;
  sii_pkg::pin_t                pins [sii_pkg::PIN_COUNT];
  sii_pkg::result_t             result;

  assign in_ch.ready  = in_ready;
  assign in_xfer      = in_ch.valid && in_ready;
  assign capture      = in_xfer && (sii_pkg::mode_t'(in_ch.mode) == sii_pkg::MODE_TICK);
  assign cfg_ch.ready = 1'b1;

  // Configuration registers; a reset e-stop item clears the whole mapping.
  always_comb begin
    enable_nxt = enable_r;
    action_nxt = action_r;
    invert_nxt = invert_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sii_pkg::REG_PIN_ENABLE: enable_nxt = cfg_ch.data[sii_pkg::MASK_W-1:0];
        sii_pkg::REG_PIN_ACTION: action_nxt = cfg_ch.data;
        sii_pkg::REG_PIN_INVERT: invert_nxt = cfg_ch.data[sii_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
    if (in_xfer && sii_pkg::mode_t'(in_ch.mode) == sii_pkg::MODE_RESET_ESTOP) begin
      enable_nxt = '0;
      action_nxt = '0;
      invert_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      action_r <= '0;
      invert_r <= '0;
    end else begin
      enable_r <= enable_nxt;
      action_r <= action_nxt;
      invert_r <= invert_nxt;
    end
  end

  // One lane per pin.
  for (genvar p = 0; p < sii_pkg::PIN_COUNT; p++) begin : g_lane
    sii_pkg::pin_cfg_t pin_cfg;

    assign pin_cfg.en     = enable_r[p];
    assign pin_cfg.invert = invert_r[p];
    assign pin_cfg.act    = sii_pkg::act_t'(action_r[2*p +: 2]);

    sii_pin_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .capture (capture),
      .level   (in_ch.input_levels[p]),
      .pin_cfg (pin_cfg),
      .pin     (pins[p])
    );
  end

  // Merge sequencer.
  assign start.xfer        = in_xfer;
  assign start.mode        = sii_pkg::mode_t'(in_ch.mode);
  assign start.pause_value = in_ch.pause_value;

  sii_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .pins      (pins),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .result    (result)
  );

  assign out_ch.paused_flag      = result.paused_flag;
  assign out_ch.estop_flag       = result.estop_flag;
  assign out_ch.home_request     = result.home_request;
  assign out_ch.hardware_advance = result.hardware_advance;

endmodule
